@@ src/bdq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the bounded deque with insert.
// No dependencies; imported by every module of the block.
package bdq_pkg;

   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int CNT_W    = 9;
   localparam int STATUS_W = 2;

   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_DUMP       = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic exec;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic dump_last;
   } dp_stat_type;

endpackage

@@ src/bdq_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the deque: shifting cell array, fill count, dump index and result register.
// Depends on bdq_pkg; driven by commands from bdq_ctrl.
module bdq_datapath
   import bdq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_stat_type                stat,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic signed [VALUE_W-1:0]  rsp_element_value,
   output logic [CNT_W-1:0]           rsp_count,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_last
);

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);

   logic [VALUE_W-1:0]  cells_ff [DEPTH];
   logic [VALUE_W-1:0]  cells_in [DEPTH];
   logic [VALUE_W-1:0]  prv      [DEPTH];
   logic [VALUE_W-1:0]  nxt      [DEPTH];
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [VALUE_W-1:0]  elem_ff, elem_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                last_ff, last_in;

   logic [CNT_W-1:0]    fill_ext;
   logic [CNT_W-1:0]    pos_ext;
   logic [CNT_W-1:0]    ins_pos;
   logic                is_empty;
   logic                is_full;
   logic                dump_last;

   assign fill_ext  = CNT_W'(fill_ff);
   assign pos_ext   = CNT_W'(req_position);
   assign is_empty  = (fill_ff == '0);
   assign is_full   = (fill_ff == FILL_W'(DEPTH));
   assign dump_last = (CNT_W'(idx_ff) == fill_ext - CNT_W'(1));

   assign stat.empty     = is_empty;
   assign stat.dump_last = dump_last;

   for (genvar g = 0; g < DEPTH; g++) begin : g_nbr
      if (g == 0) begin : g_first
         assign prv[g] = cells_ff[g];
      end else begin : g_rest
         assign prv[g] = cells_ff[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign nxt[g] = cells_ff[g];
      end else begin : g_body
         assign nxt[g] = cells_ff[g+1];
      end
   end

   always_comb begin
      unique case (req_opcode)
         OP_PUSH_FRONT: ins_pos = '0;
         OP_INSERT:     ins_pos = (pos_ext >= fill_ext) ? fill_ext : pos_ext;
         default:       ins_pos = fill_ext;
      endcase
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
      end
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      elem_in   = elem_ff;
      count_in  = count_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (cmd.exec) begin
         elem_in   = '0;
         last_in   = 1'b1;
         status_in = STAT_OK;
         idx_in    = '0;
         unique case (req_opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
               if (is_full) begin
                  status_in = STAT_FULL;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (CNT_W'(i) == ins_pos) begin
                        cells_in[i] = req_value;
                     end else if (CNT_W'(i) > ins_pos && CNT_W'(i) <= fill_ext) begin
                        cells_in[i] = prv[i];
                     end
                  end
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
            OP_POP_FRONT: begin
               if (is_empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     cells_in[i] = nxt[i];
                  end
                  fill_in = fill_ff - FILL_W'(1);
               end
            end
            OP_POP_BACK: begin
               if (is_empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  fill_in = fill_ff - FILL_W'(1);
               end
            end
            OP_DUMP: begin
               if (is_empty) begin
                  status_in = STAT_EMPTY;
               end
            end
            default: begin
            end
         endcase
         count_in = CNT_W'(fill_in);
      end else if (cmd.emit) begin
         elem_in   = cells_ff[0];
         count_in  = fill_ext;
         status_in = STAT_OK;
         last_in   = dump_last;
         idx_in    = idx_ff + IDX_W'(1);
         for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == fill_ext - CNT_W'(1)) begin
               cells_in[i] = cells_ff[0];
            end else if (CNT_W'(i) < fill_ext - CNT_W'(1)) begin
               cells_in[i] = nxt[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         idx_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      elem_ff   <= elem_in;
      count_ff  <= count_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_element_value = elem_ff;
   assign rsp_count         = count_ff;
   assign rsp_status        = status_ff;
   assign rsp_last          = last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DEPTH))
      else $error("fill count exceeds depth");

   a_pop_back: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && req_opcode == OP_POP_BACK && !is_empty
      |=> fill_ff == $past(fill_ff) - FILL_W'(1))
      else $error("pop back did not lower the fill count");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !is_empty)
      else $error("dump step on an empty list");

endmodule

@@ src/bdq_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the deque: handshakes, result valid flag and the dump sequence.
// Depends on bdq_pkg; commands bdq_datapath.
module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OPCODE_W-1:0] req_opcode,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dp_cmd_type          cmd,
   input  dp_stat_type         stat
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;
   logic accept;
   logic dump_start;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_valid && req_ready;
   assign dump_start = accept && (req_opcode == OP_DUMP) && !stat.empty;

   assign cmd.exec = accept;
   assign cmd.emit = (state_ff == ST_DUMP) && slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (dump_start) begin
               state_in = ST_DUMP;
            end
         end
         ST_DUMP: begin
            if (cmd.emit && stat.dump_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if ((accept && !dump_start) || cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_opcode != OP_DUMP |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_dump_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP && rsp_valid_ff && !rsp_ready |=> state_ff == ST_DUMP)
      else $error("dump sequence left while the receiver stalled");

   a_no_accept_in_dump: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> !accept)
      else $error("item accepted during a dump");

endmodule

@@ src/bounded_deque_with_insert_unit.sv @@
`timescale 1ns / 1ps
// Top level of the bounded deque with positional insert.
// Depends on bdq_pkg, bdq_ctrl and bdq_datapath.
//
// The req_ channel carries one operation per item: push front, push back,
// insert before a position, pop front, pop back or dump. The rsp_ channel
// returns the results; both channels use a valid/ready handshake.
// Every operation except a non-empty dump returns one item in the cycle after
// it is accepted. Outside a dump, a new item is taken in every cycle while the
// receiver keeps up, since the result register frees as it is read.
// A dump is accepted first and then returns one result per cycle while the
// receiver keeps up, read from the front cell as the list rotates once through
// the cells. The cells shift in parallel, so each push, pop and insert moves
// every affected cell at once.
// Reset empties the list and drops any pending result.
// When the receiver stalls, the pending result holds, no new item is taken and
// a dump in progress pauses.
module bounded_deque_with_insert_unit
   import bdq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [VALUE_W-1:0]  rsp_element_value,
   output logic [CNT_W-1:0]           rsp_count,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_last
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   bdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_opcode),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_element_value (rsp_element_value),
      .rsp_count         (rsp_count),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule

@@ test/bounded_deque_with_insert_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bounded_deque_with_insert_unit: a directed table, then random items.
// Checked against a behavioral deque or a typed row; random valid/ready idling in phases 1-3.
// Depends on bdq_pkg and bounded_deque_with_insert_unit.
module bounded_deque_with_insert_unit_tb;
   import bdq_pkg::*;

   localparam int DEPTH = 16;
   localparam int ITEMS_PER_PHASE = 41;
   localparam int NUM_PHASES = 4;
   localparam int TAIL_CYCLES = 40;
   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [OPCODE_W-1:0] OP_UNDEF_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_UNDEF_7 = 3'd7;

   typedef struct packed {
      logic signed [VALUE_W-1:0] elem;
      logic [CNT_W-1:0]          count;
      logic [STATUS_W-1:0]       status;
      logic                      last;
   } rsp_item_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]       op;
      logic signed [VALUE_W-1:0] val;
      logic [POS_W-1:0]          pos;
      logic [4:0]                reps;
      logic                      typed;
      logic [CNT_W-1:0]          cnt;
      logic [STATUS_W-1:0]       st;
   } stim_row_type;

   localparam int NUM_ROWS = 23;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{OP_POP_FRONT,  32'sd0,           8'd0,   5'd1,  1'b1, 9'd0,  STAT_EMPTY},
      '{OP_POP_BACK,   32'sd0,           8'd0,   5'd1,  1'b1, 9'd0,  STAT_EMPTY},
      '{OP_DUMP,       32'sd0,           8'd0,   5'd1,  1'b1, 9'd0,  STAT_EMPTY},
      '{OP_PUSH_BACK,  32'sh7FFFFFFF,    8'd0,   5'd1,  1'b1, 9'd1,  STAT_OK},
      '{OP_PUSH_FRONT, 32'sh80000000,    8'd0,   5'd1,  1'b1, 9'd2,  STAT_OK},
      '{OP_INSERT,     32'shFFFFFFFF,    8'd0,   5'd1,  1'b1, 9'd3,  STAT_OK},
      '{OP_INSERT,     32'sd0,           8'd255, 5'd1,  1'b1, 9'd4,  STAT_OK},
      '{OP_INSERT,     32'sh55555555,    8'd2,   5'd1,  1'b0, 9'd0,  STAT_OK},
      '{OP_INSERT,     32'shAAAAAAAA,    8'd4,   5'd1,  1'b0, 9'd0,  STAT_OK},
      '{OP_INSERT,     32'sh12345678,    8'd6,   5'd1,  1'b0, 9'd0,  STAT_OK},
      '{OP_UNDEF_6,    32'shFFFFFFFF,    8'd255, 5'd1,  1'b1, 9'd7,  STAT_OK},
      '{OP_UNDEF_7,    32'sh0000FFFF,    8'd1,   5'd1,  1'b1, 9'd7,  STAT_OK},
      '{OP_DUMP,       32'sd0,           8'd0,   5'd1,  1'b0, 9'd0,  STAT_OK},
      '{OP_POP_FRONT,  32'sd0,           8'd0,   5'd1,  1'b0, 9'd0,  STAT_OK},
      '{OP_POP_BACK,   32'sd0,           8'd0,   5'd1,  1'b0, 9'd0,  STAT_OK},
      '{OP_PUSH_BACK,  32'sh0F0F0F00,    8'd0,   5'd11, 1'b0, 9'd0,  STAT_OK},
      '{OP_PUSH_FRONT, 32'sh01020304,    8'd0,   5'd1,  1'b1, 9'd16, STAT_FULL},
      '{OP_PUSH_BACK,  32'sh01020304,    8'd0,   5'd1,  1'b1, 9'd16, STAT_FULL},
      '{OP_INSERT,     32'sh01020304,    8'd128, 5'd1,  1'b1, 9'd16, STAT_FULL},
      '{OP_DUMP,       32'sd0,           8'd0,   5'd1,  1'b0, 9'd0,  STAT_OK},
      '{OP_POP_BACK,   32'sd0,           8'd0,   5'd15, 1'b0, 9'd0,  STAT_OK},
      '{OP_POP_FRONT,  32'sd0,           8'd0,   5'd1,  1'b1, 9'd0,  STAT_OK},
      '{OP_POP_FRONT,  32'sd0,           8'd0,   5'd1,  1'b1, 9'd0,  STAT_EMPTY}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OPCODE_W-1:0]       req_opcode = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_element_value;
   logic [CNT_W-1:0]          rsp_count;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      rsp_last;

   logic                      drv_typed = 1'b0;
   logic [CNT_W-1:0]          drv_typed_cnt = '0;
   logic [STATUS_W-1:0]       drv_typed_st = '0;

   int sender_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int idle_cycles = 0;

   logic signed [VALUE_W-1:0] model_cells [DEPTH];
   int                        model_fill = 0;
   rsp_item_type              model_out [$];
   rsp_item_type              expected_rsp [$];

   bounded_deque_with_insert_unit #(.DEPTH(DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_element_value(rsp_element_value),
      .rsp_count(rsp_count),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void deque_step(input logic [OPCODE_W-1:0] op,
                                      input logic signed [VALUE_W-1:0] val,
                                      input logic [POS_W-1:0] pos);
      int slot;
      int i;
      rsp_item_type r;
      model_out.delete();
      r.elem = '0;
      r.count = CNT_W'(model_fill);
      r.status = STAT_OK;
      r.last = 1'b1;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
            if (model_fill >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               if (op == OP_PUSH_FRONT) slot = 0;
               else if (op == OP_PUSH_BACK || int'(pos) >= model_fill) slot = model_fill;
               else slot = int'(pos);
               for (i = model_fill; i > slot; i--) model_cells[i] = model_cells[i - 1];
               model_cells[slot] = val;
               model_fill++;
               r.count = CNT_W'(model_fill);
            end
            model_out.push_back(r);
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (model_fill == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               if (op == OP_POP_FRONT) begin
                  for (i = 1; i < model_fill; i++) model_cells[i - 1] = model_cells[i];
               end
               model_fill--;
               r.count = CNT_W'(model_fill);
            end
            model_out.push_back(r);
         end
         OP_DUMP: begin
            if (model_fill == 0) begin
               r.status = STAT_EMPTY;
               model_out.push_back(r);
            end else begin
               for (i = 0; i < model_fill; i++) begin
                  r.elem = model_cells[i];
                  r.last = (i == model_fill - 1);
                  model_out.push_back(r);
               end
            end
         end
         default: model_out.push_back(r);
      endcase
   endfunction

   // Prediction happens when an item is accepted; results are checked in order.
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type ex;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_element_value, rsp_count, rsp_status, rsp_last};
         if (expected_rsp.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected result: elem %0d count %0d status %0d last %0d",
                        got.elem, got.count, got.status, got.last);
         end else begin
            ex = expected_rsp.pop_front();
            if (got !== ex) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display({"mismatch: expected elem %0d count %0d status %0d last %0d,",
                            " got elem %0d count %0d status %0d last %0d"},
                           ex.elem, ex.count, ex.status, ex.last,
                           got.elem, got.count, got.status, got.last);
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         deque_step(req_opcode, req_value, req_position);
         if (drv_typed) begin
            ex = '{'0, drv_typed_cnt, drv_typed_st, 1'b1};
            expected_rsp.push_back(ex);
         end else begin
            foreach (model_out[k]) expected_rsp.push_back(model_out[k]);
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("status: fail");
         $finish;
      end
   end

   // Entered and left at a falling edge; valid is assigned at most once per falling edge.
   task automatic send_item(input logic [OPCODE_W-1:0] op,
                            input logic signed [VALUE_W-1:0] val,
                            input logic [POS_W-1:0] pos,
                            input logic typed,
                            input logic [CNT_W-1:0] cnt,
                            input logic [STATUS_W-1:0] st);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_value <= val;
      req_position <= pos;
      drv_typed <= typed;
      drv_typed_cnt <= cnt;
      drv_typed_st <= st;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
   endtask

   initial begin
      int row;
      int k;
      int ph;
      int n;
      int r;
      bit grow;
      logic [OPCODE_W-1:0] op;
      logic signed [VALUE_W-1:0] val;
      logic [POS_W-1:0] pos;
      int phase_idle [NUM_PHASES];
      int phase_stall [NUM_PHASES];
      phase_idle = '{0, 72, 0, 30};
      phase_stall = '{0, 0, 72, 30};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row = 0; row < NUM_ROWS; row++) begin
         for (k = 0; k < int'(DIRECTED_ROWS[row].reps); k++) begin
            send_item(DIRECTED_ROWS[row].op, DIRECTED_ROWS[row].val + k,
                      DIRECTED_ROWS[row].pos, DIRECTED_ROWS[row].typed,
                      DIRECTED_ROWS[row].cnt, DIRECTED_ROWS[row].st);
         end
      end
      wait_drain();

      grow = 1'b1;
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         sender_idle_pct = phase_idle[ph];
         recv_stall_pct = phase_stall[ph];
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (model_fill == DEPTH && $urandom_range(2) == 0) grow = 1'b0;
            if (model_fill == 0 && $urandom_range(2) == 0) grow = 1'b1;
            r = $urandom_range(99);
            if (r < 3) begin
               op = ($urandom_range(1) == 0) ? OP_UNDEF_6 : OP_UNDEF_7;
            end else if (r < 13) begin
               op = OP_DUMP;
            end else if ($urandom_range(99) < (grow ? 70 : 25)) begin
               case ($urandom_range(2))
                  0: op = OP_PUSH_FRONT;
                  1: op = OP_PUSH_BACK;
                  default: op = OP_INSERT;
               endcase
            end else begin
               op = ($urandom_range(1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
            end
            case ($urandom_range(11))
               0: val = 32'sh7FFFFFFF;
               1: val = 32'sh80000000;
               2: val = 32'shFFFFFFFF;
               default: val = $urandom;
            endcase
            if ($urandom_range(3) == 0) pos = POS_W'($urandom_range(255));
            else pos = POS_W'($urandom_range(model_fill + 1));
            send_item(op, val, pos, 1'b0, '0, STAT_OK);
         end
         wait_drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         error_count++;
         $display("%0d expected results never arrived", expected_rsp.size());
      end
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
